// ----- design/wsd_pkg.sv -----
// ---------------------------------------------------------------------------
// wsd_pkg
// Shared codes and result type for the frame deframer.
// ---------------------------------------------------------------------------
package wsd_pkg;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  localparam logic [1:0] EV_DATA  = 2'd0;
  localparam logic [1:0] EV_CLOSE = 2'd1;
  localparam logic [1:0] EV_PONG  = 2'd2;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] data_byte;
    logic       text_frame;
    logic       frame_last;
  } result_t;

endpackage

// ----- design/wsd_in_stage.sv -----
// ---------------------------------------------------------------------------
// wsd_in_stage
// Input register holding one received byte until the parser takes it.
// ---------------------------------------------------------------------------
module wsd_in_stage
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  // refill in the same cycle the parser takes the held word
  assign s_tready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      held_byte <= s_tdata;
    end
  end

endmodule

// ----- design/wsd_parser.sv -----
// ---------------------------------------------------------------------------
// wsd_parser
// Frame header state machine and payload unmasking, one byte per step.
// ---------------------------------------------------------------------------
module wsd_parser
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD,
    PH_CLOSED
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  opcode, opcode_next;
  logic        mask_on, mask_on_next;
  logic [63:0] remaining, remaining_next;
  logic [3:0]  hdr_count, hdr_count_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_pos, mask_pos_next;

  logic [63:0] rem_dec;
  logic [3:0]  cnt_dec;
  logic [7:0]  key_byte;
  logic [6:0]  len7;
  logic        is_data;

  assign rem_dec = remaining - 64'd1;
  assign cnt_dec = hdr_count - 4'd1;
  assign len7    = rx_byte[6:0];
  assign is_data = (opcode == OP_TEXT) || (opcode == OP_BINARY);

  always_comb begin
    unique case (mask_pos)
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      2'd3: key_byte = mask_key[7:0];
      default: key_byte = mask_key[31:24];
    endcase
  end

  always_comb begin
    logic end_frame;
    end_frame      = 1'b0;
    phase_next     = phase;
    opcode_next    = opcode;
    mask_on_next   = mask_on;
    remaining_next = remaining;
    hdr_count_next = hdr_count;
    mask_key_next  = mask_key;
    mask_pos_next  = mask_pos;
    res_valid      = 1'b0;
    res            = '0;

    unique case (phase)
      PH_HDR0: begin
        opcode_next = rx_byte[3:0];
        phase_next  = PH_HDR1;
      end
      PH_HDR1: begin
        mask_on_next   = rx_byte[7];
        mask_key_next  = '0;
        mask_pos_next  = '0;
        remaining_next = '0;
        if (len7 == LEN_EXT16) begin
          phase_next     = PH_EXTLEN;
          hdr_count_next = 4'd2;
        end else if (len7 == LEN_EXT64) begin
          phase_next     = PH_EXTLEN;
          hdr_count_next = 4'd8;
        end else begin
          remaining_next = {57'd0, len7};
          if (rx_byte[7]) begin
            phase_next     = PH_MASK;
            hdr_count_next = 4'd4;
          end else if (len7 == 7'd0) begin
            end_frame = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_EXTLEN: begin
        remaining_next = {remaining[55:0], rx_byte};
        hdr_count_next = cnt_dec;
        if (cnt_dec == 4'd0) begin
          mask_pos_next = '0;
          if (mask_on) begin
            phase_next     = PH_MASK;
            hdr_count_next = 4'd4;
          end else if (remaining_next == 64'd0) begin
            end_frame = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_MASK: begin
        mask_key_next  = {mask_key[23:0], rx_byte};
        hdr_count_next = cnt_dec;
        if (cnt_dec == 4'd0) begin
          mask_pos_next = '0;
          if (remaining == 64'd0) begin
            end_frame = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        mask_pos_next  = mask_pos + 2'd1;
        remaining_next = rem_dec;
        if (is_data) begin
          res_valid      = 1'b1;
          res.event_kind = EV_DATA;
          res.data_byte  = rx_byte ^ key_byte;
          res.text_frame = (opcode == OP_TEXT);
          res.frame_last = (rem_dec == 64'd0);
          if (rem_dec == 64'd0) begin
            phase_next = PH_HDR0;
          end
        end else if (rem_dec == 64'd0) begin
          end_frame = 1'b1;
        end
      end
      default: begin
        // closed: every byte is dropped until reset
      end
    endcase

    if (end_frame) begin
      phase_next = PH_HDR0;
      if (opcode == OP_CLOSE) begin
        phase_next     = PH_CLOSED;
        res_valid      = 1'b1;
        res.event_kind = EV_CLOSE;
      end else if (opcode == OP_PING) begin
        res_valid      = 1'b1;
        res.event_kind = EV_PONG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR0;
      opcode    <= '0;
      mask_on   <= 1'b0;
      remaining <= '0;
      hdr_count <= '0;
      mask_key  <= '0;
      mask_pos  <= '0;
    end else if (step) begin
      phase     <= phase_next;
      opcode    <= opcode_next;
      mask_on   <= mask_on_next;
      remaining <= remaining_next;
      hdr_count <= hdr_count_next;
      mask_key  <= mask_key_next;
      mask_pos  <= mask_pos_next;
    end
  end

endmodule

// ----- design/wsd_out_stage.sv -----
// ---------------------------------------------------------------------------
// wsd_out_stage
// Result register driving the master-side stream.
// ---------------------------------------------------------------------------
module wsd_out_stage
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  result_t    res,
  output logic       room,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic [2:0] m_tuser,
  output logic       m_tlast
);

  result_t held;

  assign room     = !m_tvalid || m_tready;
  assign m_tdata  = held.data_byte;
  assign m_tuser  = {held.text_frame, held.event_kind};
  assign m_tlast  = held.frame_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (room) begin
      m_tvalid <= load;
    end
    if (room && load) begin
      held <= res;
    end
  end

endmodule

// ----- design/websocket_frame_deframer.sv -----
// ---------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side frame parser: header decode, payload unmasking, control events.
// ---------------------------------------------------------------------------
// Usage:
//   The slave-side stream carries the received connection bytes, one byte
//   per word, starting at the first header byte after the handshake.
//   The master-side stream carries one word per payload byte of text and
//   binary frames (unmasked, tlast on the final byte of a frame), plus a
//   close event at the end of a close frame and a pong request at the end
//   of a ping frame. Header bytes and the payload of other frames give no
//   word.
//   A result word reaches the master side through the input register and
//   the result register: the parser works on the accepted byte while it
//   sits in the input register, and the result register loads when the
//   parser steps. One byte is taken every cycle while the master side
//   takes words; the rate is set by the parser step with its 64-bit
//   length count. When the receiver stalls, the result register holds its
//   word and the input register fills, after which s_tready drops.
//   Reset clears the parser to expect a new frame header and empties both
//   registers. After a close event every byte is taken and dropped until
//   the next reset.
// ---------------------------------------------------------------------------
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] data_byte
  output logic [2:0] m_tuser,   // [1:0] event_kind, [2] text_frame
  output logic       m_tlast    // frame_last
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       room;
  logic       step;
  logic       res_valid;
  result_t    res;

  assign step = held_valid && room;

  wsd_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .take      (step),
    .held_valid(held_valid),
    .held_byte (held_byte)
  );

  wsd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .rx_byte  (held_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  wsd_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (step && res_valid),
    .res     (res),
    .room    (room),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

// ----- design/wsd_checker.sv -----
// ---------------------------------------------------------------------------
// wsd_checker
// Port-level checks on the deframer result stream.
// ---------------------------------------------------------------------------
module wsd_checker
  import wsd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [2:0] m_tuser,
  input logic       m_tlast
);

  logic closed_seen;
  logic in_accept;

  assign in_accept = s_tvalid && s_tready && (s_tdata == s_tdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      closed_seen <= 1'b0;
    end else if (m_tvalid && m_tready && (m_tuser[1:0] == EV_CLOSE)) begin
      closed_seen <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result word changed");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[1:0] != 2'd3)
    else $error("result kind without meaning");

  a_event: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1:0] != EV_DATA) |->
      (m_tdata == 8'd0) && !m_tlast && !m_tuser[2])
    else $error("event word carries payload fields");

  a_closed: assert property (@(posedge clk) disable iff (rst)
    closed_seen && in_accept |=> !(closed_seen && m_tvalid && !$past(m_tvalid)))
    else $error("result word after close event");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);
